>>> rtl/lca_binary_lifting_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ancestor query block
// Shorthand for concurrent checks clocked on clock, with or without reset.
// ----------------------------------------------------------------------------
`ifndef LCA_BINARY_LIFTING_ASSERT_SVH
`define LCA_BINARY_LIFTING_ASSERT_SVH

// Checked only while reset is low.
`define LCABL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define LCABL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/lcabl_pkg.sv
// ----------------------------------------------------------------------------
// lcabl_pkg
// Shared sizes, codes and the control and status bundles of the block.
// ----------------------------------------------------------------------------
package lcabl_pkg;

   localparam int NODES   = 1024;
   localparam int LEVELS  = 10;
   localparam int NODE_W  = $clog2(NODES);
   localparam int DEPTH_W = 10;
   localparam int DIST_W  = 11;
   localparam int OP_W    = 2;
   localparam int LEVEL_W = $clog2(LEVELS + 1);

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(1023);

   localparam logic [OP_W-1:0] OP_ATTACH = 2'd0;
   localparam logic [OP_W-1:0] OP_KTH    = 2'd1;
   localparam logic [OP_W-1:0] OP_LCA    = 2'd2;

   typedef struct packed {
      logic [DEPTH_W-1:0]            depth;
      logic [LEVELS-1:0][NODE_W-1:0] anc;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_CLEAR,
      DP_RD_PARENT,
      DP_ATT_SEED,
      DP_ATT_RD,
      DP_ATT_SELF,
      DP_ATT_TAKE,
      DP_ATT_WR,
      DP_RD_AB,
      DP_KTH_SET,
      DP_LCA_SET,
      DP_RD_U,
      DP_CL_TAKE,
      DP_RD_UV,
      DP_J_TAKE
   } dp_op_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_ATTACH,
      RES_NODE,
      RES_LCA
   } res_type;

   typedef struct packed {
      dp_op_type          dp_op;
      logic [LEVEL_W-1:0] level;
      logic [NODE_W-1:0]  clr_addr;
      logic               res_load;
      res_type            res_sel;
      logic               par_take;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            a_zero;
      logic            self_ref;
      logic            depth_short;
      logic            k_bit;
      logic            same;
   } status_type;

endpackage

>>> rtl/lcabl_req_if.sv
// ----------------------------------------------------------------------------
// lcabl_req_if
// Request channel: one query or attach word per handshake.
// ----------------------------------------------------------------------------
interface lcabl_req_if;
   logic                        valid;
   logic                        ready;
   logic [lcabl_pkg::OP_W-1:0]   operation;
   logic [lcabl_pkg::NODE_W-1:0] node_a;
   logic [lcabl_pkg::NODE_W-1:0] node_b;
   logic [lcabl_pkg::NODE_W-1:0] step_count;

   modport source (output valid, operation, node_a, node_b, step_count, input ready);
   modport sink   (input valid, operation, node_a, node_b, step_count, output ready);
endinterface

>>> rtl/lcabl_rsp_if.sv
// ----------------------------------------------------------------------------
// lcabl_rsp_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface lcabl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lcabl_pkg::NODE_W-1:0] node_out;
   logic [lcabl_pkg::DIST_W-1:0] distance;
   logic                        found;

   modport source (output valid, node_out, distance, found, input ready);
   modport sink   (input valid, node_out, distance, found, output ready);
endinterface

>>> rtl/lcabl_ram.sv
// ----------------------------------------------------------------------------
// lcabl_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module lcabl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_a_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic                     rd_b_en,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

>>> rtl/lcabl_datapath.sv
// ----------------------------------------------------------------------------
// lcabl_datapath
// Node table, query registers and the result word register.
// ----------------------------------------------------------------------------
module lcabl_datapath (
   input  logic                         clock,
   input  lcabl_pkg::cmd_type           cmd,
   output lcabl_pkg::status_type        status,
   input  logic [lcabl_pkg::OP_W-1:0]   req_operation,
   input  logic [lcabl_pkg::NODE_W-1:0] req_node_a,
   input  logic [lcabl_pkg::NODE_W-1:0] req_node_b,
   input  logic [lcabl_pkg::NODE_W-1:0] req_step_count,
   output logic [lcabl_pkg::NODE_W-1:0] rsp_node_out,
   output logic [lcabl_pkg::DIST_W-1:0] rsp_distance,
   output logic                         rsp_found
);
   import lcabl_pkg::*;

   logic [OP_W-1:0]               op_ff;
   logic [NODE_W-1:0]             a_ff;
   logic [NODE_W-1:0]             b_ff;
   logic [NODE_W-1:0]             k_ff;
   logic [NODE_W-1:0]             u_ff;
   logic [NODE_W-1:0]             v_ff;
   logic [DEPTH_W-1:0]            da_ff;
   logic [DEPTH_W-1:0]            db_ff;
   logic [DEPTH_W-1:0]            dnew_ff;
   logic [LEVELS-1:0][NODE_W-1:0] row_ff;
   logic [NODE_W-1:0]             node_ff;
   logic [DIST_W-1:0]             dist_ff;
   logic                          found_ff;

   logic                 wr_en;
   logic [NODE_W-1:0]    wr_addr;
   logic [ROW_W-1:0]     wr_data;
   logic                 rd_a_en;
   logic [NODE_W-1:0]    rd_a_addr;
   logic                 rd_b_en;
   logic [NODE_W-1:0]    rd_b_addr;
   logic [ROW_W-1:0]     rd_a_raw;
   logic [ROW_W-1:0]     rd_b_raw;
   row_type              rd_a;
   row_type              rd_b;
   row_type              new_row;
   logic [LEVEL_W-1:0]   lvl;
   logic [LEVEL_W-1:0]   lvl_m1;
   logic [DIST_W-1:0]    sum_w;
   logic [DIST_W-1:0]    twice_w;

   assign rd_a    = row_type'(rd_a_raw);
   assign rd_b    = row_type'(rd_b_raw);
   assign lvl     = cmd.level;
   assign lvl_m1  = cmd.level - LEVEL_W'(1);
   assign sum_w   = DIST_W'(da_ff) + DIST_W'(db_ff);
   assign twice_w = DIST_W'({rd_a.depth, 1'b0});

   always_comb begin
      new_row.depth = dnew_ff;
      new_row.anc   = row_ff;
   end

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = a_ff;
      wr_data   = ROW_W'(new_row);
      rd_a_en   = 1'b0;
      rd_a_addr = u_ff;
      rd_b_en   = 1'b0;
      rd_b_addr = v_ff;
      case (cmd.dp_op)
         DP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cmd.clr_addr;
            wr_data = '0;
         end
         DP_ATT_WR: begin
            wr_en = 1'b1;
         end
         DP_RD_PARENT: begin
            rd_a_en   = 1'b1;
            rd_a_addr = b_ff;
         end
         DP_ATT_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = row_ff[lvl_m1];
         end
         DP_RD_AB: begin
            rd_a_en   = 1'b1;
            rd_a_addr = a_ff;
            rd_b_en   = 1'b1;
            rd_b_addr = b_ff;
         end
         DP_RD_U: begin
            rd_a_en = 1'b1;
         end
         DP_RD_UV: begin
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
         end
         default: begin
         end
      endcase
      if (cmd.par_take) begin
         rd_a_en   = 1'b1;
         rd_a_addr = rd_a.anc[0];
      end
   end

   lcabl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NODES)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_en   (rd_a_en),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_raw),
      .rd_b_en   (rd_b_en),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_raw)
   );

   always_ff @(posedge clock) begin
      case (cmd.dp_op)
         DP_CAPTURE: begin
            op_ff <= req_operation;
            a_ff  <= req_node_a;
            b_ff  <= req_node_b;
            k_ff  <= req_step_count;
         end
         DP_ATT_SEED: begin
            dnew_ff   <= (rd_a.depth == DEPTH_MAX) ? DEPTH_MAX : rd_a.depth + DEPTH_W'(1);
            row_ff[0] <= b_ff;
            row_ff[1] <= (b_ff == a_ff) ? b_ff : rd_a.anc[0];
         end
         DP_ATT_SELF: begin
            row_ff[lvl] <= row_ff[lvl_m1];
         end
         DP_ATT_TAKE: begin
            row_ff[lvl] <= rd_a.anc[lvl_m1];
         end
         DP_KTH_SET: begin
            u_ff <= a_ff;
         end
         DP_LCA_SET: begin
            da_ff <= rd_a.depth;
            db_ff <= rd_b.depth;
            if (rd_a.depth < rd_b.depth) begin
               u_ff <= b_ff;
               v_ff <= a_ff;
               k_ff <= rd_b.depth - rd_a.depth;
            end else begin
               u_ff <= a_ff;
               v_ff <= b_ff;
               k_ff <= rd_a.depth - rd_b.depth;
            end
         end
         DP_CL_TAKE: begin
            u_ff <= rd_a.anc[lvl];
         end
         DP_J_TAKE: begin
            if (rd_a.anc[lvl] != rd_b.anc[lvl]) begin
               u_ff <= rd_a.anc[lvl];
               v_ff <= rd_b.anc[lvl];
            end
         end
         default: begin
         end
      endcase

      if (cmd.par_take) begin
         u_ff <= rd_a.anc[0];
      end

      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_ATTACH: begin
               node_ff  <= a_ff;
               dist_ff  <= '0;
               found_ff <= 1'b1;
            end
            RES_NODE: begin
               node_ff  <= u_ff;
               dist_ff  <= '0;
               found_ff <= 1'b1;
            end
            RES_LCA: begin
               node_ff  <= u_ff;
               dist_ff  <= (sum_w < twice_w) ? '0 : sum_w - twice_w;
               found_ff <= 1'b1;
            end
            default: begin
               node_ff  <= '0;
               dist_ff  <= '0;
               found_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      status.op          = op_ff;
      status.a_zero      = (a_ff == '0);
      status.self_ref    = (row_ff[lvl_m1] == a_ff);
      status.depth_short = (rd_a.depth < k_ff);
      status.k_bit       = k_ff[lvl];
      status.same        = (u_ff == v_ff);
   end

   assign rsp_node_out = node_ff;
   assign rsp_distance = dist_ff;
   assign rsp_found    = found_ff;

endmodule

>>> rtl/lcabl_ctrl.sv
// ----------------------------------------------------------------------------
// lcabl_ctrl
// Sequencer for table clearing, attach, ancestor climbing and joint lifting.
// ----------------------------------------------------------------------------
`include "lca_binary_lifting_assert.svh"

module lcabl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lcabl_pkg::cmd_type    cmd,
   input  lcabl_pkg::status_type status
);
   import lcabl_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ATT_SEED,
      ST_ATT_RD,
      ST_ATT_TAKE,
      ST_KTH_CHK,
      ST_LCA_SET,
      ST_CLIMB,
      ST_CL_TAKE,
      ST_L_EQ,
      ST_J_RD,
      ST_J_TAKE,
      ST_L_PAR,
      ST_L_WAIT,
      ST_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [NODE_W-1:0]  clr_ff, clr_in;
   res_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               par_ff, par_in;
   logic               last_level;
   logic               is_lca;

   assign last_level = (level_ff == '0);
   assign is_lca     = (status.op == OP_LCA);

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      par_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.dp_op    = DP_NOP;
      cmd.level    = level_ff;
      cmd.clr_addr = clr_ff;
      cmd.res_load = 1'b0;
      cmd.res_sel  = res_ff;
      cmd.par_take = par_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.dp_op = DP_CLEAR;
            clr_in    = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.dp_op = DP_CAPTURE;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               OP_ATTACH: begin
                  if (status.a_zero) begin
                     res_in   = RES_ZERO;
                     state_in = ST_FIN;
                  end else begin
                     cmd.dp_op = DP_RD_PARENT;
                     state_in  = ST_ATT_SEED;
                  end
               end
               OP_KTH: begin
                  cmd.dp_op = DP_RD_AB;
                  state_in  = ST_KTH_CHK;
               end
               OP_LCA: begin
                  cmd.dp_op = DP_RD_AB;
                  state_in  = ST_LCA_SET;
               end
               default: begin
                  res_in   = RES_ZERO;
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_ATT_SEED: begin
            cmd.dp_op = DP_ATT_SEED;
            level_in  = LEVEL_W'(2);
            state_in  = ST_ATT_RD;
         end
         ST_ATT_RD: begin
            if (level_ff == LEVEL_W'(LEVELS)) begin
               cmd.dp_op = DP_ATT_WR;
               res_in    = RES_ATTACH;
               state_in  = ST_FIN;
            end else if (status.self_ref) begin
               cmd.dp_op = DP_ATT_SELF;
               level_in  = level_ff + LEVEL_W'(1);
            end else begin
               cmd.dp_op = DP_ATT_RD;
               state_in  = ST_ATT_TAKE;
            end
         end
         ST_ATT_TAKE: begin
            cmd.dp_op = DP_ATT_TAKE;
            level_in  = level_ff + LEVEL_W'(1);
            state_in  = ST_ATT_RD;
         end
         ST_KTH_CHK: begin
            if (status.depth_short) begin
               res_in   = RES_ZERO;
               state_in = ST_FIN;
            end else begin
               cmd.dp_op = DP_KTH_SET;
               level_in  = LEVEL_W'(LEVELS - 1);
               state_in  = ST_CLIMB;
            end
         end
         ST_LCA_SET: begin
            cmd.dp_op = DP_LCA_SET;
            level_in  = LEVEL_W'(LEVELS - 1);
            state_in  = ST_CLIMB;
         end
         ST_CLIMB: begin
            if (status.k_bit) begin
               cmd.dp_op = DP_RD_U;
               state_in  = ST_CL_TAKE;
            end else if (!last_level) begin
               level_in = level_ff - LEVEL_W'(1);
            end else if (is_lca) begin
               state_in = ST_L_EQ;
            end else begin
               res_in   = RES_NODE;
               state_in = ST_FIN;
            end
         end
         ST_CL_TAKE: begin
            cmd.dp_op = DP_CL_TAKE;
            if (!last_level) begin
               level_in = level_ff - LEVEL_W'(1);
               state_in = ST_CLIMB;
            end else if (is_lca) begin
               state_in = ST_L_EQ;
            end else begin
               res_in   = RES_NODE;
               state_in = ST_FIN;
            end
         end
         ST_L_EQ: begin
            if (par_ff) begin
               state_in = ST_L_WAIT;
            end else if (status.same) begin
               cmd.dp_op = DP_RD_U;
               state_in  = ST_L_WAIT;
            end else begin
               level_in = LEVEL_W'(LEVELS - 1);
               state_in = ST_J_RD;
            end
         end
         ST_J_RD: begin
            cmd.dp_op = DP_RD_UV;
            state_in  = ST_J_TAKE;
         end
         ST_J_TAKE: begin
            cmd.dp_op = DP_J_TAKE;
            if (last_level) begin
               state_in = ST_L_PAR;
            end else begin
               level_in = level_ff - LEVEL_W'(1);
               state_in = ST_J_RD;
            end
         end
         ST_L_PAR: begin
            // Read the lower node's row; its first ancestor is taken next cycle.
            cmd.dp_op = DP_RD_U;
            par_in    = 1'b1;
            state_in  = ST_L_EQ;
         end
         ST_L_WAIT: begin
            res_in   = RES_LCA;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         level_ff     <= '0;
         clr_ff       <= '0;
         res_ff       <= RES_ZERO;
         rsp_valid_ff <= 1'b0;
         par_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         clr_ff       <= clr_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
         par_ff       <= par_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `LCABL_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> state_ff == ST_CLEAR, "no clearing pass after reset")
   `LCABL_ASSERT(a_level_range, level_ff <= LEVEL_W'(LEVELS), "level counter out of range")
   `LCABL_ASSERT(a_no_overwrite, (cmd.res_load && rsp_valid_ff) |-> rsp_ready, "pending word overwritten")
   `LCABL_ASSERT(a_one_at_a_time, (req_valid && req_ready) |=> !req_ready, "second word taken while busy")

endmodule

>>> rtl/lca_binary_lifting.sv
// The table has one row per node, read through a RAM with registered read data,
// so each dependent ancestor lookup is a read followed by a take step; one word
// is in work at a time. A finished word waits in the response register while the
// next request is taken. After reset a clearing pass zeroes every row of the table;
// requests wait meanwhile.
// ----------------------------------------------------------------------------
// lca_binary_lifting
// Binary-lifting ancestor table with attach, kth ancestor and lca queries.
// ----------------------------------------------------------------------------
module lca_binary_lifting (
   input  logic        clock,
   input  logic        reset,
   lcabl_req_if.sink   req_chan,
   lcabl_rsp_if.source rsp_chan
);
   import lcabl_pkg::*;

   cmd_type    cmd;
   status_type status;

   lcabl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lcabl_datapath u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_chan.operation),
      .req_node_a     (req_chan.node_a),
      .req_node_b     (req_chan.node_b),
      .req_step_count (req_chan.step_count),
      .rsp_node_out   (rsp_chan.node_out),
      .rsp_distance   (rsp_chan.distance),
      .rsp_found      (rsp_chan.found)
   );

endmodule
